// ===== sv/vrt_pkg.sv =====
// ----------------------------------------------------------------------------
// vrt_pkg: shared types and constants of the variable reference tokenizer
// Character codes, register indexes, marker reset codes, and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package vrt_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_MAX     = 8'hFF;
  localparam logic [7:0] CH_E_UP    = 8'h45;
  localparam logic [7:0] CH_E_LO    = 8'h65;
  localparam logic [7:0] CH_U_UP    = 8'h55;
  localparam logic [7:0] CH_U_LO    = 8'h75;
  localparam logic [7:0] CH_N_UP    = 8'h4E;
  localparam logic [7:0] CH_N_LO    = 8'h6E;

  // Register indexes
  localparam logic [1:0] REG_ESCAPE   = 2'd0;
  localparam logic [1:0] REG_UNESCAPE = 2'd1;
  localparam logic [1:0] REG_PLAIN    = 2'd2;
  localparam logic [1:0] REG_END      = 2'd3;

  // Register reset codes
  localparam logic [7:0] ESCAPE_RST   = 8'd64;
  localparam logic [7:0] UNESCAPE_RST = 8'd65;
  localparam logic [7:0] PLAIN_RST    = 8'd66;
  localparam logic [7:0] END_RST      = 8'd1;

  // Words an item produces, in emission order
  typedef struct packed {
    logic f1;    // flush of the reference open before the item
    logic f2;    // flush of an empty reference opened and closed by the item
    logic dol;   // lone dollar as text
    logic tail;  // text byte or final zero
  } plan_t;

  // Source of the next output word
  typedef enum logic [2:0] {
    SRC_MARK1,
    SRC_NAME,
    SRC_END1,
    SRC_MARK2,
    SRC_END2,
    SRC_DOLLAR,
    SRC_TAIL
  } src_e;

  typedef struct packed {
    logic idle;
    logic load;
    logic push;
    src_e sel;
    logic idx_clr;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    plan_t plan_now;
    plan_t plan;
    logic  out_free;
    logic  name_empty;
    logic  name_last;
  } status_t;

endpackage

// ===== sv/vrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// vrt_ctrl: word sequencer of the variable reference tokenizer
// Walks the words one item produces: marker, name, end token, empty
// reference, lone dollar, text byte or final zero.
// ----------------------------------------------------------------------------
module vrt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  vrt_pkg::status_t status_i,
  output vrt_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK1,
    ST_NAME,
    ST_END1,
    ST_MARK2,
    ST_END2,
    ST_DOLLAR,
    ST_TAIL
  } state_e;

  state_e state_q, state_d;
  vrt_pkg::plan_t p_after1, p_after2, p_after3;

  function automatic state_e first_of(vrt_pkg::plan_t p);
    state_e s;
    if (p.f1)        s = ST_MARK1;
    else if (p.f2)   s = ST_MARK2;
    else if (p.dol)  s = ST_DOLLAR;
    else if (p.tail) s = ST_TAIL;
    else             s = ST_IDLE;
    return s;
  endfunction

  always_comb begin
    p_after1 = status_i.plan;
    p_after1.f1 = 1'b0;
    p_after2 = p_after1;
    p_after2.f2 = 1'b0;
    p_after3 = p_after2;
    p_after3.dol = 1'b0;
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o.idle    = (state_q == ST_IDLE);
    cmd_o.load    = in_valid_i && (state_q == ST_IDLE);
    cmd_o.push    = (state_q != ST_IDLE) && status_i.out_free;
    cmd_o.idx_clr = (state_q != ST_NAME);
    cmd_o.idx_inc = (state_q == ST_NAME) && status_i.out_free && !status_i.name_last;
    case (state_q)
      ST_MARK1:  cmd_o.sel = vrt_pkg::SRC_MARK1;
      ST_NAME:   cmd_o.sel = vrt_pkg::SRC_NAME;
      ST_END1:   cmd_o.sel = vrt_pkg::SRC_END1;
      ST_MARK2:  cmd_o.sel = vrt_pkg::SRC_MARK2;
      ST_END2:   cmd_o.sel = vrt_pkg::SRC_END2;
      ST_DOLLAR: cmd_o.sel = vrt_pkg::SRC_DOLLAR;
      default:   cmd_o.sel = vrt_pkg::SRC_TAIL;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) state_d = first_of(status_i.plan_now);
      end
      ST_MARK1: begin
        if (status_i.out_free) state_d = status_i.name_empty ? ST_END1 : ST_NAME;
      end
      ST_NAME: begin
        if (status_i.out_free && status_i.name_last) state_d = ST_END1;
      end
      ST_END1: begin
        if (status_i.out_free) state_d = first_of(p_after1);
      end
      ST_MARK2: begin
        if (status_i.out_free) state_d = ST_END2;
      end
      ST_END2: begin
        if (status_i.out_free) state_d = first_of(p_after2);
      end
      ST_DOLLAR: begin
        if (status_i.out_free) state_d = first_of(p_after3);
      end
      ST_TAIL: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Name words are only walked for a non-empty name
  a_name_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_NAME |-> !status_i.name_empty)
    else $error("name walk on empty name");

  // Never overwrite an undelivered word
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> status_i.out_free)
    else $error("push into occupied output register");

endmodule

// ===== sv/vrt_datapath.sv =====
// ----------------------------------------------------------------------------
// vrt_datapath: scan state, name memory and output register
// Decodes one input byte into a word plan and next scan state, holds the
// flush snapshot, the name memory and the output register.
// ----------------------------------------------------------------------------
module vrt_datapath #(
  parameter int MAX_NAME = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       in_byte_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             out_ready_i,
  input  vrt_pkg::cmd_t    cmd_i,
  output vrt_pkg::status_t status_o,
  output logic             out_valid_o,
  output logic [7:0]       out_byte_o,
  output logic             string_done_o,
  output logic             name_truncated_o
);

  localparam int LW = $clog2(MAX_NAME + 1);
  localparam int AW = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
  localparam logic [LW-1:0] MaxLen = LW'(MAX_NAME);

  // Registers
  logic [7:0] esc_q, unesc_q, plain_q, end_q;

  // Scan state
  logic          in_ref_q, typed_q, await_q, pend_q, ovf_q;
  logic [7:0]    mk_q;
  logic [LW-1:0] len_q;

  logic          nx_inref, nx_typed, nx_await, nx_pend, nx_ovf;
  logic [7:0]    nx_mk;
  logic [LW-1:0] nx_len;

  // Plan of the item being decoded
  vrt_pkg::plan_t pl;
  logic [7:0]     tail_b, f1_mk, app_b;
  logic           tail_done, app, app_req, opened, do_proc, pflush;
  logic [AW-1:0]  app_idx;

  // Plan of the item in flight
  vrt_pkg::plan_t plan_q;
  logic [7:0]     tail_b_q, f1_mk_q, wr_b_q;
  logic           tail_done_q, f1_trunc_q, wr_pend_q;
  logic [LW-1:0]  f1_len_q;
  logic [AW-1:0]  wr_idx_q;

  // Name memory
  logic [7:0]    name_mem [MAX_NAME];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] idx_q, idx_d;
  logic          wr_fire;

  // Output register
  logic       out_valid_q, done_q, trunc_q;
  logic [7:0] out_byte_q;
  logic [7:0] push_byte;
  logic       push_done, push_trunc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= vrt_pkg::ESCAPE_RST;
      unesc_q <= vrt_pkg::UNESCAPE_RST;
      plain_q <= vrt_pkg::PLAIN_RST;
      end_q   <= vrt_pkg::END_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vrt_pkg::REG_ESCAPE:   esc_q   <= cfg_data_i;
        vrt_pkg::REG_UNESCAPE: unesc_q <= cfg_data_i;
        vrt_pkg::REG_PLAIN:    plain_q <= cfg_data_i;
        default:               end_q   <= cfg_data_i;
      endcase
    end
  end

  // Decode one byte
  always_comb begin
    nx_inref  = in_ref_q;
    nx_typed  = typed_q;
    nx_await  = 1'b0;
    nx_pend   = pend_q;
    nx_mk     = mk_q;
    nx_len    = len_q;
    nx_ovf    = ovf_q;
    pl        = '0;
    tail_b    = in_byte_i;
    tail_done = 1'b0;
    app       = 1'b0;
    app_req   = 1'b0;
    app_b     = in_byte_i;
    app_idx   = '0;
    opened    = 1'b0;
    do_proc   = 1'b0;
    pflush    = 1'b0;

    if (await_q) begin
      case (in_byte_i)
        vrt_pkg::CH_E_LO, vrt_pkg::CH_E_UP: nx_mk = esc_q;
        vrt_pkg::CH_U_LO, vrt_pkg::CH_U_UP: nx_mk = unesc_q;
        vrt_pkg::CH_N_LO, vrt_pkg::CH_N_UP: nx_mk = plain_q;
        default: ;
      endcase
    end
    f1_mk = nx_mk;

    // Resolve a held dollar
    if (pend_q) begin
      nx_pend = 1'b0;
      if (in_byte_i == vrt_pkg::CH_DOLLAR) begin
        if (in_ref_q) begin
          app_req = 1'b1;
          app_b   = vrt_pkg::CH_DOLLAR;
        end else begin
          pl.tail = 1'b1;
        end
      end else if (in_ref_q && typed_q) begin
        do_proc = 1'b1;
      end else begin
        if (in_ref_q) begin
          pl.f1    = 1'b1;
          nx_inref = 1'b0;
          nx_typed = 1'b0;
          nx_len   = '0;
          nx_ovf   = 1'b0;
        end
        if (in_byte_i == vrt_pkg::CH_SPACE) begin
          pl.dol  = 1'b1;
          do_proc = 1'b1;
        end else begin
          opened   = 1'b1;
          nx_inref = 1'b1;
          nx_typed = 1'b0;
          nx_mk    = plain_q;
          nx_len   = '0;
          nx_ovf   = 1'b0;
          do_proc  = (in_byte_i != vrt_pkg::CH_LPAREN);
        end
      end
    end else begin
      do_proc = 1'b1;
    end

    // Ordinary byte handling
    if (do_proc) begin
      if (in_byte_i == vrt_pkg::CH_DOLLAR) begin
        nx_pend = 1'b1;
      end else if (in_byte_i == vrt_pkg::CH_NUL) begin
        pflush    = nx_inref;
        pl.tail   = 1'b1;
        tail_done = 1'b1;
      end else if (nx_inref && nx_typed) begin
        if (in_byte_i == vrt_pkg::CH_SPACE || in_byte_i == vrt_pkg::CH_RPAREN) begin
          pflush  = 1'b1;
          pl.tail = (in_byte_i == vrt_pkg::CH_SPACE);
        end
      end else if (nx_inref && in_byte_i == vrt_pkg::CH_COLON) begin
        nx_typed = 1'b1;
        nx_await = 1'b1;
      end else if (nx_inref && (in_byte_i inside {[vrt_pkg::CH_NUL:vrt_pkg::CH_ZERO],
                                                  [vrt_pkg::CH_NINE:vrt_pkg::CH_UPPER_A],
                                                  [vrt_pkg::CH_LOWER_Z:vrt_pkg::CH_MAX]})) begin
        pflush  = 1'b1;
        pl.tail = (in_byte_i != vrt_pkg::CH_RPAREN);
      end else if (nx_inref) begin
        app_req = 1'b1;
      end else begin
        pl.tail = 1'b1;
      end
    end

    if (pflush) begin
      if (opened) pl.f2 = 1'b1;
      else        pl.f1 = 1'b1;
      nx_inref = 1'b0;
      nx_typed = 1'b0;
      nx_await = 1'b0;
      nx_len   = '0;
      nx_ovf   = 1'b0;
    end

    // String end: back to the start-of-string state
    if (do_proc && in_byte_i == vrt_pkg::CH_NUL) begin
      nx_pend = 1'b0;
      nx_mk   = plain_q;
    end

    if (app_req) begin
      if (nx_len < MaxLen) begin
        app     = 1'b1;
        app_idx = AW'(nx_len);
        nx_len  = nx_len + LW'(1);
      end else begin
        nx_ovf = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ref_q  <= 1'b0;
      typed_q   <= 1'b0;
      await_q   <= 1'b0;
      pend_q    <= 1'b0;
      mk_q      <= vrt_pkg::PLAIN_RST;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      plan_q    <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        in_ref_q  <= nx_inref;
        typed_q   <= nx_typed;
        await_q   <= nx_await;
        pend_q    <= nx_pend;
        mk_q      <= nx_mk;
        len_q     <= nx_len;
        ovf_q     <= nx_ovf;
        plan_q    <= pl;
        wr_pend_q <= app;
      end else if (wr_fire) begin
        wr_pend_q <= 1'b0;
      end
    end
  end

  // Flush snapshot and text byte of the item in flight
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tail_b_q    <= tail_b;
      tail_done_q <= tail_done;
      f1_mk_q     <= f1_mk;
      f1_len_q    <= len_q;
      f1_trunc_q  <= ovf_q;
      wr_b_q      <= app_b;
      wr_idx_q    <= app_idx;
    end
  end

  // Name write waits until the sequencer is idle, after any flush read
  assign wr_fire = cmd_i.idle && wr_pend_q;

  always_comb begin
    if (cmd_i.idx_inc)      idx_d = idx_q + AW'(1);
    else if (cmd_i.idx_clr) idx_d = '0;
    else                    idx_d = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) name_mem[wr_idx_q] <= wr_b_q;
    rd_data_q <= name_mem[idx_d];
  end

  // Output word source
  always_comb begin
    push_done  = 1'b0;
    push_trunc = 1'b0;
    case (cmd_i.sel)
      vrt_pkg::SRC_MARK1:  push_byte = f1_mk_q;
      vrt_pkg::SRC_NAME:   push_byte = rd_data_q;
      vrt_pkg::SRC_END1: begin
        push_byte  = end_q;
        push_trunc = f1_trunc_q;
      end
      vrt_pkg::SRC_MARK2:  push_byte = plain_q;
      vrt_pkg::SRC_END2:   push_byte = end_q;
      vrt_pkg::SRC_DOLLAR: push_byte = vrt_pkg::CH_DOLLAR;
      default: begin
        push_byte = tail_b_q;
        push_done = tail_done_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_byte_q <= push_byte;
      done_q     <= push_done;
      trunc_q    <= push_trunc;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign string_done_o    = done_q;
  assign name_truncated_o = trunc_q;

  always_comb begin
    status_o.plan_now   = pl;
    status_o.plan       = plan_q;
    status_o.out_free   = !out_valid_q || out_ready_i;
    status_o.name_empty = (f1_len_q == '0);
    status_o.name_last  = (LW'(idx_q) + LW'(1) == f1_len_q);
  end

  // Final zero word carries a zero byte and never a truncation flag
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> out_byte_q == vrt_pkg::CH_NUL && !trunc_q)
    else $error("final word is not a plain zero");

  // Name reads stay within the snapshot length
  a_name_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push && cmd_i.sel == vrt_pkg::SRC_NAME |-> LW'(idx_q) < f1_len_q)
    else $error("name read past stored length");

endmodule

// ===== sv/variable_reference_tokenizer.sv =====
// ----------------------------------------------------------------------------
// variable_reference_tokenizer: $name / $(name:type) reference tokenizer
// Streams a zero-terminated string and rewrites each variable reference as
// a marker token, the buffered name bytes and an end token.
// ----------------------------------------------------------------------------
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------
//   in      | in_valid_i/in_ready_o | in_byte_i
//   out     | out_valid_o/out_ready_i | out_byte_o, string_done_o,
//           |                       |   name_truncated_o
//   cfg     | cfg_we_i (no wait)    | cfg_idx_i, cfg_data_i
//
// Words: a byte that produces no word leaves the sequencer idle; otherwise it
//   is accepted and one output word issues per sequencer state; a closing
//   byte gives marker, name words, end token and any following words, one
//   name word per cycle from the single name memory read port, output free.
// Reset: asynchronous, active low; registers return to their reset codes,
//   scan state to start of string. The name memory needs no clearing pass.
// Stalls: input is taken only between items; a word waiting in the output
//   register does not block acceptance of the next byte.
// ----------------------------------------------------------------------------
module variable_reference_tokenizer #(
  parameter int MAX_NAME = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input bytes
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  // Output words
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       string_done_o,
  output logic       name_truncated_o,
  // Register writes
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  vrt_pkg::cmd_t    cmd;
  vrt_pkg::status_t status;

  // Sequencer: walks the words of one item, one word per free output slot
  vrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: byte decode, name memory, flush snapshot and output register
  vrt_datapath #(
    .MAX_NAME (MAX_NAME)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_byte_i        (in_byte_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (out_ready_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_byte_o       (out_byte_o),
    .string_done_o    (string_done_o),
    .name_truncated_o (name_truncated_o)
  );

endmodule

// ===== tb/variable_reference_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// variable_reference_tokenizer_tb: self-checking bench for the tokenizer
// Streams zero-terminated strings through the byte channel and predicts every
// output word with an untimed model of the scan rules. Compares each word
// taken from the output channel with the oldest prediction. Both channels
// idle at random, and the marker registers change between strings.
// ----------------------------------------------------------------------------
module variable_reference_tokenizer_tb;

  localparam int MAX_NAME      = 32;
  // Quiet time after the last predicted word: covers a full name flush
  localparam int SETTLE_CYCLES = 2 * MAX_NAME + 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BYTES  = 12;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       done;
    logic       trunc;
  } word_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i        = '0;
  logic       out_valid_o;
  logic       out_ready_i      = 1'b0;
  logic [7:0] out_byte_o;
  logic       string_done_o;
  logic       name_truncated_o;
  logic       cfg_we_i         = 1'b0;
  logic [1:0] cfg_idx_i        = '0;
  logic [7:0] cfg_data_i       = '0;

  always #5 clk_i = ~clk_i;

  variable_reference_tokenizer #(
    .MAX_NAME(MAX_NAME)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .string_done_o   (string_done_o),
    .name_truncated_o(name_truncated_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  int          err_count   = 0;
  int unsigned cycle_count = 0;
  int          stall_left  = 0;
  bit          idle_in_en  = 1'b1;  // sender gaps between bytes
  bit          idle_out_en = 1'b1;  // receiver stalls between words

  word_t predicted_words[$];

  // Marker registers as the block should hold them
  logic [7:0] esc_code;
  logic [7:0] unesc_code;
  logic [7:0] plain_code;
  logic [7:0] end_code;

  // Scan state of the tokenizer model
  logic       in_ref;
  logic       typed;
  logic       await_type;
  logic       dollar_held;
  logic       name_over;
  logic [7:0] cur_marker;
  logic [7:0] name_buf [MAX_NAME];
  int         name_len;

  // --------------------------------------------------------------------------
  // Tokenizer model: one call per accepted input byte, words go to the queue
  // --------------------------------------------------------------------------
  function automatic void push_word(input logic [7:0] data, input logic done,
                                    input logic trunc);
    word_t w;
    w.data  = data;
    w.done  = done;
    w.trunc = trunc;
    predicted_words.push_back(w);
  endfunction

  function automatic void clear_scan();
    in_ref      = 1'b0;
    typed       = 1'b0;
    await_type  = 1'b0;
    dollar_held = 1'b0;
    cur_marker  = plain_code;
    name_len    = 0;
    name_over   = 1'b0;
  endfunction

  function automatic void reset_model();
    esc_code   = vrt_pkg::ESCAPE_RST;
    unesc_code = vrt_pkg::UNESCAPE_RST;
    plain_code = vrt_pkg::PLAIN_RST;
    end_code   = vrt_pkg::END_RST;
    clear_scan();
  endfunction

  // Marker, buffered name, end token; then close the reference
  function automatic void emit_reference();
    push_word(cur_marker, 1'b0, 1'b0);
    for (int k = 0; k < name_len; k++) push_word(name_buf[k], 1'b0, 1'b0);
    push_word(end_code, 1'b0, name_over);
    in_ref     = 1'b0;
    typed      = 1'b0;
    await_type = 1'b0;
    name_len   = 0;
    name_over  = 1'b0;
  endfunction

  // Keep the first MAX_NAME name bytes; flag the rest as dropped
  function automatic void add_name_char(input logic [7:0] c);
    if (name_len < MAX_NAME) begin
      name_buf[name_len] = c;
      name_len++;
    end else begin
      name_over = 1'b1;
    end
  endfunction

  function automatic bit ends_name(input logic [7:0] c);
    return c == vrt_pkg::CH_SPACE || c == vrt_pkg::CH_RPAREN || c == vrt_pkg::CH_DOLLAR ||
           c <= vrt_pkg::CH_ZERO ||
           (c >= vrt_pkg::CH_NINE && c <= vrt_pkg::CH_UPPER_A) ||
           c >= vrt_pkg::CH_LOWER_Z;
  endfunction

  // Handle a byte with no dollar waiting in front of it
  function automatic void scan_char(input logic [7:0] c);
    if (c == vrt_pkg::CH_DOLLAR) begin
      dollar_held = 1'b1;
    end else if (c == vrt_pkg::CH_NUL) begin
      if (in_ref) emit_reference();
      push_word(vrt_pkg::CH_NUL, 1'b1, 1'b0);
      clear_scan();
    end else if (in_ref && typed) begin
      // Type part: drop all but the two closers; pass the space on as text
      if (c == vrt_pkg::CH_SPACE || c == vrt_pkg::CH_RPAREN) begin
        emit_reference();
        if (c == vrt_pkg::CH_SPACE) push_word(c, 1'b0, 1'b0);
      end
    end else if (in_ref && c == vrt_pkg::CH_COLON) begin
      typed      = 1'b1;
      await_type = 1'b1;
    end else if (in_ref && ends_name(c)) begin
      emit_reference();
      if (c != vrt_pkg::CH_RPAREN) push_word(c, 1'b0, 1'b0);
    end else if (in_ref) begin
      add_name_char(c);
    end else begin
      push_word(c, 1'b0, 1'b0);
    end
  endfunction

  // Resolve a held dollar against the byte that follows it
  function automatic void settle_dollar(input logic [7:0] n);
    dollar_held = 1'b0;
    if (n == vrt_pkg::CH_DOLLAR) begin
      if (in_ref) add_name_char(vrt_pkg::CH_DOLLAR);
      else push_word(vrt_pkg::CH_DOLLAR, 1'b0, 1'b0);
    end else if (in_ref && typed) begin
      scan_char(n);
    end else begin
      if (in_ref) emit_reference();
      if (n == vrt_pkg::CH_SPACE) begin
        // Lone dollar stays text
        push_word(vrt_pkg::CH_DOLLAR, 1'b0, 1'b0);
        scan_char(n);
      end else begin
        in_ref     = 1'b1;
        typed      = 1'b0;
        cur_marker = plain_code;
        name_len   = 0;
        name_over  = 1'b0;
        if (n != vrt_pkg::CH_LPAREN) scan_char(n);
      end
    end
  endfunction

  function automatic void tokenize_byte(input logic [7:0] c);
    // The type letter picks the marker before anything else sees the byte
    if (await_type) begin
      await_type = 1'b0;
      if (c == vrt_pkg::CH_E_LO || c == vrt_pkg::CH_E_UP) cur_marker = esc_code;
      else if (c == vrt_pkg::CH_U_LO || c == vrt_pkg::CH_U_UP) cur_marker = unesc_code;
      else if (c == vrt_pkg::CH_N_LO || c == vrt_pkg::CH_N_UP) cur_marker = plain_code;
    end
    if (dollar_held) settle_dollar(c);
    else scan_char(c);
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random stalls and the word checker
  // --------------------------------------------------------------------------
  // Draw a fresh stall after every word taken; hold ready low while it runs
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) stall_left = idle_out_en ? $urandom_range(8, 0) : 0;
    else if (stall_left > 0) stall_left = stall_left - 1;
    out_ready_i <= (stall_left == 0);
  end

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      err_count++;
    end
  endfunction

  // Compare every word taken against the oldest prediction
  always @(posedge clk_i) begin : check_words
    word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual %0h/%b/%b", $time,
                 out_byte_o, string_done_o, name_truncated_o);
        err_count++;
      end else begin
        want = predicted_words.pop_front();
        check_field("out_byte", want.data, out_byte_o);
        check_field("string_done", {7'd0, want.done}, {7'd0, string_done_o});
        check_field("name_truncated", {7'd0, want.trunc}, {7'd0, name_truncated_o});
      end
    end
  end

  // Hard stop if the block hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("variable_reference_tokenizer regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side: byte sender, register writes, drain
  // --------------------------------------------------------------------------
  // Send one byte; return at the edge that took it, valid still high
  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = idle_in_en ? $urandom_range(8, 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
    tokenize_byte(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // Drop valid and hold until every predicted word has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (predicted_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; write enable is left for the caller to drop
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      vrt_pkg::REG_ESCAPE:   esc_code   = val;
      vrt_pkg::REG_UNESCAPE: unesc_code = val;
      vrt_pkg::REG_PLAIN:    plain_code = val;
      vrt_pkg::REG_END:      end_code   = val;
      default:               ;
    endcase
  endtask

  task automatic load_markers(input logic [7:0] esc, input logic [7:0] unesc,
                              input logic [7:0] pln, input logic [7:0] fin);
    wait_idle();
    write_reg(vrt_pkg::REG_ESCAPE, esc);
    write_reg(vrt_pkg::REG_UNESCAPE, unesc);
    write_reg(vrt_pkg::REG_PLAIN, pln);
    write_reg(vrt_pkg::REG_END, fin);
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random string builder
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(hi, lo);
    return r[7:0];
  endfunction

  // Bytes that extend a name
  function automatic logic [7:0] name_char();
    if ($urandom_range(1, 0)) return rand_byte(vrt_pkg::CH_ZERO + 1, vrt_pkg::CH_NINE - 1);
    return rand_byte(vrt_pkg::CH_UPPER_A + 1, vrt_pkg::CH_LOWER_Z - 1);
  endfunction

  function automatic logic [7:0] type_letter();
    case ($urandom_range(6, 0))
      0:       return vrt_pkg::CH_E_LO;
      1:       return vrt_pkg::CH_E_UP;
      2:       return vrt_pkg::CH_U_LO;
      3:       return vrt_pkg::CH_U_UP;
      4:       return vrt_pkg::CH_N_LO;
      5:       return vrt_pkg::CH_N_UP;
      default: return rand_byte(1, vrt_pkg::CH_MAX);
    endcase
  endfunction

  function automatic logic [7:0] closer_byte();
    case ($urandom_range(5, 0))
      0:       return vrt_pkg::CH_RPAREN;
      1:       return vrt_pkg::CH_SPACE;
      2:       return rand_byte(1, vrt_pkg::CH_ZERO);
      3:       return rand_byte(vrt_pkg::CH_NINE, vrt_pkg::CH_UPPER_A);
      4:       return rand_byte(vrt_pkg::CH_LOWER_Z, vrt_pkg::CH_MAX);
      default: return vrt_pkg::CH_DOLLAR;
    endcase
  endfunction

  // Mostly well-formed references with random names, types and closers,
  // mixed with noise, doubled and lone dollars; always zero-terminated
  function automatic byte_q_t random_string();
    byte_q_t     s;
    int unsigned len;
    for (int p = $urandom_range(4, 1); p > 0; p--) begin
      case ($urandom_range(9, 0))
        0: begin
          for (int k = $urandom_range(3, 1); k > 0; k--)
            s.push_back(rand_byte(1, vrt_pkg::CH_MAX));
        end
        1: begin
          s.push_back(vrt_pkg::CH_DOLLAR);
          s.push_back(vrt_pkg::CH_DOLLAR);
        end
        2: begin
          s.push_back(vrt_pkg::CH_DOLLAR);
          s.push_back(vrt_pkg::CH_SPACE);
        end
        default: begin
          s.push_back(vrt_pkg::CH_DOLLAR);
          if ($urandom_range(1, 0)) s.push_back(vrt_pkg::CH_LPAREN);
          // Keep names short; now and then run past the buffer
          len = ($urandom_range(9, 0) == 0) ? $urandom_range(MAX_NAME + 4, MAX_NAME - 2)
                                            : $urandom_range(5, 0);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(11, 0) == 0) begin
              s.push_back(vrt_pkg::CH_DOLLAR);
              s.push_back(vrt_pkg::CH_DOLLAR);
            end else begin
              s.push_back(name_char());
            end
          end
          if ($urandom_range(2, 0) == 0) begin
            s.push_back(vrt_pkg::CH_COLON);
            s.push_back(type_letter());
            if ($urandom_range(2, 0) == 0) s.push_back(rand_byte(1, vrt_pkg::CH_MAX));
          end
          if ($urandom_range(5, 0) != 0) s.push_back(closer_byte());
        end
      endcase
    end
    // Sometimes end on a held dollar
    if ($urandom_range(4, 0) == 0) s.push_back(vrt_pkg::CH_DOLLAR);
    s.push_back(vrt_pkg::CH_NUL);
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Hand-picked strings at reset markers: paren and typed forms, doubled and
  // lone dollars, closers, a top byte in the type part, unclosed references
  task automatic test_directed();
    send_text("$(x:U) $y$$z");
    send_byte(vrt_pkg::CH_NUL);
    send_text("$ $$$e0$a:E");
    send_byte(vrt_pkg::CH_MAX);
    send_byte(vrt_pkg::CH_NUL);
    send_text("$a$b$");
    send_byte(vrt_pkg::CH_NUL);
  endtask

  // Name past the buffer, closed by a paren
  task automatic test_long_name();
    send_byte(vrt_pkg::CH_DOLLAR);
    for (int k = 0; k < MAX_NAME + 3; k++) send_byte(name_char());
    send_byte(vrt_pkg::CH_RPAREN);
    send_byte(vrt_pkg::CH_NUL);
  endtask

  // All-zero markers, all-ones markers, then a random mix
  task automatic test_marker_extremes();
    for (int i = 0; i < 3; i++) begin
      case (i)
        0:       load_markers(8'h00, 8'h00, 8'h00, 8'h00);
        1:       load_markers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        default: load_markers(rand_byte(0, vrt_pkg::CH_MAX), rand_byte(0, vrt_pkg::CH_MAX),
                              rand_byte(0, vrt_pkg::CH_MAX), rand_byte(0, vrt_pkg::CH_MAX));
      endcase
      send_text("$a:e $b:U)$c");
      send_byte(vrt_pkg::CH_NUL);
    end
  endtask

  // Back-to-back words on both channels
  task automatic test_burst();
    wait_idle();
    idle_in_en  = 1'b0;
    idle_out_en = 1'b0;
    send_bytes(random_string());
    wait_idle();
    idle_in_en  = 1'b1;
    idle_out_en = 1'b1;
  endtask

  // Random strings; markers change now and then, and the sender holds in
  // the middle of the first string until the output side has drained
  task automatic test_random_strings();
    byte_q_t s;
    int      sent;
    bit      held;
    sent = 0;
    held = 1'b0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(3, 0) == 0)
        load_markers(rand_byte(0, vrt_pkg::CH_MAX), rand_byte(0, vrt_pkg::CH_MAX),
                     rand_byte(0, vrt_pkg::CH_MAX), rand_byte(0, vrt_pkg::CH_MAX));
      s = random_string();
      foreach (s[i]) begin
        if (!held && i == s.size() / 2) begin
          wait_idle();
          held = 1'b1;
        end
        send_byte(s[i]);
      end
      sent += s.size();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_long_name();
    test_marker_extremes();
    test_burst();
    test_random_strings();
    wait_idle();
    if (err_count == 0) begin
      $display("variable_reference_tokenizer regression: pass");
    end else begin
      $display("variable_reference_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
